// ===== sv/stup_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stup_pkg: shared types and constants of the string to unsigned parser
// Word and index widths, parser phase codes, character and base codes, the
// parser state and result records and the digit and blank decode functions.
// ----------------------------------------------------------------------------
package stup_pkg;

  localparam int WORD_BITS  = 32;
  localparam int INDEX_BITS = 16;
  localparam int BASE_BITS  = 6;
  localparam int CHAR_BITS  = 8;
  localparam int DATA_BITS  = 32;
  localparam int ADDR_BITS  = 3;

  // parser phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LEAD   = 3'd1;
  localparam logic [2:0] PH_SIGNED = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  // register index of the base register
  localparam logic REG_RADIX = 1'b0;

  // character codes
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UC_Z  = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LC_Z  = 8'h7A;
  localparam logic [CHAR_BITS-1:0] CH_UC_X  = 8'h58;
  localparam logic [CHAR_BITS-1:0] CH_LC_X  = 8'h78;

  // letter offsets: 'A' - 10 and 'a' - 10
  localparam logic [CHAR_BITS-1:0] UC_OFFSET = CH_UC_A - 8'd10;
  localparam logic [CHAR_BITS-1:0] LC_OFFSET = CH_LC_A - 8'd10;

  // fixed bases picked from the prefix
  localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;

  // not a digit: at least as large as any base the register can hold
  localparam logic [BASE_BITS-1:0] DIGIT_NONE = {BASE_BITS{1'b1}};

  typedef struct packed {
    logic [2:0]            phase;
    logic [WORD_BITS-1:0]  acc;
    logic                  neg;
    logic                  saw;
    logic                  ovf;
    logic [BASE_BITS-1:0]  base;
    logic [INDEX_BITS-1:0] pos;
  } stup_state_t;

  typedef struct packed {
    logic                  emit;
    logic [WORD_BITS-1:0]  value;
    logic [INDEX_BITS-1:0] end_index;
    logic                  any_digits;
    logic                  overflow;
  } stup_result_t;

  // value of a digit or letter, DIGIT_NONE for anything else
  function automatic logic [BASE_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] v;
    if (c >= CH_0 && c <= CH_9) begin
      v = c - CH_0;
    end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
      v = c - LC_OFFSET;
    end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
      v = c - UC_OFFSET;
    end else begin
      v = {{(CHAR_BITS-BASE_BITS){1'b0}}, DIGIT_NONE};
    end
    return v[BASE_BITS-1:0];
  endfunction

  // tab, line feed, vertical tab, form feed, carriage return or space
  function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

// ===== sv/stup_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stup_step: one character step of the parser
// Works out the next parser state and the result, if this character ends
// the number. One 32 by 6 multiply-add with its overflow check.
// ----------------------------------------------------------------------------
module stup_step
  import stup_pkg::*;
(
  input  stup_state_t          cur,
  input  logic [CHAR_BITS-1:0] ch,
  input  logic                 first,
  input  logic [BASE_BITS-1:0] radix,
  output stup_state_t          nxt,
  output stup_result_t         res
);

  localparam int PROD_BITS = WORD_BITS + BASE_BITS + 1;

  stup_state_t           s;
  logic                  go;
  logic                  do_feed;
  logic                  start;
  logic [BASE_BITS-1:0]  d;
  logic [PROD_BITS-1:0]  prod;

  always_comb begin
    s       = cur;
    go      = 1'b0;
    do_feed = 1'b0;
    start   = 1'b0;
    prod    = '0;
    res     = '0;
    d       = digit_of(ch);

    // restart on the first flag, otherwise run only inside a string
    if (first) begin
      s.phase = PH_LEAD;
      s.acc   = '0;
      s.neg   = 1'b0;
      s.saw   = 1'b0;
      s.ovf   = 1'b0;
      s.base  = radix;
      s.pos   = '0;
      go      = 1'b1;
    end else begin
      go = (cur.phase != PH_IDLE) && (cur.phase != PH_DONE);
    end

    // prefix handling
    if (go) begin
      case (s.phase)
        PH_LEAD: begin
          if (is_space(ch)) begin
            s.phase = PH_LEAD;
          end else if (ch == CH_MINUS) begin
            s.neg   = 1'b1;
            s.phase = PH_SIGNED;
          end else if (ch == CH_PLUS) begin
            s.phase = PH_SIGNED;
          end else begin
            start = 1'b1;
          end
        end
        PH_SIGNED: begin
          start = 1'b1;
        end
        PH_ZERO: begin
          s.phase = PH_DIGITS;
          if (ch == CH_LC_X || ch == CH_UC_X) begin
            s.base = BASE_HEX;
          end else begin
            // the held leading zero counts as a digit
            if (s.base == BASE_AUTO) s.base = BASE_OCT;
            s.saw   = 1'b1;
            do_feed = 1'b1;
          end
        end
        PH_DIGITS: begin
          do_feed = 1'b1;
        end
        default: begin
          s.phase = cur.phase;
        end
      endcase
    end

    // first character of the number proper
    if (start) begin
      if ((s.base == BASE_AUTO || s.base == BASE_HEX) && ch == CH_0) begin
        s.phase = PH_ZERO;
      end else begin
        if (s.base == BASE_AUTO) s.base = BASE_DEC;
        s.phase = PH_DIGITS;
        do_feed = 1'b1;
      end
    end

    // accumulate a digit or close the number
    if (do_feed) begin
      if (d >= s.base) begin
        res.emit       = 1'b1;
        res.any_digits = s.saw;
        res.overflow   = s.ovf;
        res.end_index  = s.saw ? s.pos : '0;
        if (s.ovf) begin
          res.value = {WORD_BITS{1'b1}};
        end else if (s.neg) begin
          res.value = '0 - s.acc;
        end else begin
          res.value = s.acc;
        end
        s.phase = PH_DONE;
      end else begin
        prod = ({{(BASE_BITS+1){1'b0}}, s.acc} * {{(WORD_BITS+1){1'b0}}, s.base})
             + {{(WORD_BITS+1){1'b0}}, d};
        if (s.ovf || (|prod[PROD_BITS-1:WORD_BITS])) begin
          s.ovf = 1'b1;
        end else begin
          s.acc = prod[WORD_BITS-1:0];
        end
        s.saw = 1'b1;
      end
    end

    // advance the position, holding at its maximum
    if (go && !res.emit && (s.pos != {INDEX_BITS{1'b1}})) begin
      s.pos = s.pos + 1'b1;
    end

    nxt = s;
  end

endmodule

// ===== sv/string_to_unsigned_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_to_unsigned_parser: streaming strtoul-style integer parser
//
//   channel  direction  handshake          beat contents
//   in_      input      in_valid/in_stall  ch, first
//   out_     output     out_valid/out_stall value, end_index, any_digits,
//                                          overflow
//   cfg      APB        psel/penable       radix register at address 0
//
// One character per cycle, sustained while no result is held under out_stall;
// a character passes an input register and the step logic (one 32 by 6
// multiply-add) into the parser state and, if it ends a number, the result register.
// Reset is synchronous on rst_n and clears the parser state, the radix and both valid flags.
// While a result waits under out_stall a full input register holds and in_stall
// rises; an empty input register is refilled in the same cycle.
// ----------------------------------------------------------------------------
module string_to_unsigned_parser
  import stup_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAR_BITS-1:0]  in_ch,
  input  logic                  in_first,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [WORD_BITS-1:0]  out_value,
  output logic [INDEX_BITS-1:0] out_end_index,
  output logic                  out_any_digits,
  output logic                  out_overflow,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready
);

  logic [BASE_BITS-1:0] radix_r;
  logic                 in_valid_r;
  logic [CHAR_BITS-1:0] ch_r;
  logic                 first_r;
  stup_state_t          state_r;
  stup_state_t          state_nxt;
  stup_result_t         res;
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] value_r;
  logic [INDEX_BITS-1:0] end_index_r;
  logic                 any_digits_r;
  logic                 overflow_r;
  logic                 fire;
  logic                 in_take;
  logic                 out_take;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_BITS-1] == REG_RADIX) ?
                  {{(DATA_BITS-BASE_BITS){1'b0}}, radix_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= '0;
    end else if (psel && penable && pwrite && (paddr[ADDR_BITS-1] == REG_RADIX)) begin
      radix_r <= pwdata[BASE_BITS-1:0];
    end
  end

  // handshakes: step the held beat unless a result is stuck at the output
  assign out_take = out_valid_r && !out_stall;
  assign fire     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !fire;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ch_r    <= in_ch;
      first_r <= in_first;
    end
  end

  stup_step u_step (
    .cur   (state_r),
    .ch    (ch_r),
    .first (first_r),
    .radix (radix_r),
    .nxt   (state_nxt),
    .res   (res)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_IDLE, acc: '0, neg: 1'b0, saw: 1'b0, ovf: 1'b0,
                   base: '0, pos: '0};
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.emit) begin
      value_r      <= res.value;
      end_index_r  <= res.end_index;
      any_digits_r <= res.any_digits;
      overflow_r   <= res.overflow;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = value_r;
  assign out_end_index  = end_index_r;
  assign out_any_digits = any_digits_r;
  assign out_overflow   = overflow_r;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for string_to_unsigned_parser
// Streams characters into the parser and checks every result beat against a
// behavioral parser kept inside the bench, or against the result typed into a
// directed row. A short directed table comes first. Random number strings and
// noise follow under changing radix settings. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import stup_pkg::*;

  typedef struct packed {
    logic [WORD_BITS-1:0]  value;
    logic [INDEX_BITS-1:0] end_index;
    logic                  any_digits;
    logic                  overflow;
  } num_t;

  typedef struct packed {
    logic                 set_radix;
    logic [BASE_BITS-1:0] radix;
    logic [CHAR_BITS-1:0] ch;
    logic                 first;
    logic                 typed;
    num_t                 res;
  } dir_row_t;

  localparam num_t NO_NUM = '0;
  localparam logic [ADDR_BITS-1:0] RADIX_ADDR = ADDR_BITS'(4 * REG_RADIX);
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int N_DIRECTED    = 29;

  // directed rows; a result is typed in where it is obvious
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // before any string start: ignored
    '{1'b0, 6'd0, "Z",   1'b0, 1'b0, NO_NUM},
    // " -0xfF" then NUL, radix from reset (auto)
    '{1'b0, 6'd0, " ",   1'b1, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "-",   1'b0, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "0",   1'b0, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "x",   1'b0, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "f",   1'b0, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "F",   1'b0, 1'b0, NO_NUM},
    '{1'b0, 6'd0, 8'h00, 1'b0, 1'b1, '{32'hFFFF_FF01, 16'd6, 1'b1, 1'b0}},
    // after a result: ignored
    '{1'b0, 6'd0, "7",   1'b0, 1'b0, NO_NUM},
    // hex prefix with no digit behind it
    '{1'b0, 6'd0, "0",   1'b1, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "X",   1'b0, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "g",   1'b0, 1'b1, '{32'd0, 16'd0, 1'b0, 1'b0}},
    // leading zero selects octal, so 8 ends the number
    '{1'b0, 6'd0, "0",   1'b1, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "7",   1'b0, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "8",   1'b0, 1'b1, '{32'd7, 16'd2, 1'b1, 1'b0}},
    // restart in mid string drops the first one
    '{1'b0, 6'd0, "9",   1'b1, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "9",   1'b1, 1'b0, NO_NUM},
    '{1'b0, 6'd0, 8'h80, 1'b0, 1'b1, '{32'd9, 16'd1, 1'b1, 1'b0}},
    // sign followed by a blank: no digits
    '{1'b0, 6'd0, "+",   1'b1, 1'b0, NO_NUM},
    '{1'b0, 6'd0, 8'h0A, 1'b0, 1'b1, '{32'd0, 16'd0, 1'b0, 1'b0}},
    // base 36 overflow with a minus sign: all ones
    '{1'b1, 6'd36, "-",  1'b1, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "z",   1'b0, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "z",   1'b0, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "z",   1'b0, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "Z",   1'b0, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "z",   1'b0, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "z",   1'b0, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "z",   1'b0, 1'b0, NO_NUM},
    '{1'b0, 6'd0, "!",   1'b0, 1'b1, '{32'hFFFF_FFFF, 16'd8, 1'b1, 1'b1}}
  };

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [CHAR_BITS-1:0]  in_ch     = '0;
  logic                  in_first  = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [WORD_BITS-1:0]  out_value;
  logic [INDEX_BITS-1:0] out_end_index;
  logic                  out_any_digits;
  logic                  out_overflow;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [ADDR_BITS-1:0]  paddr     = '0;
  logic [DATA_BITS-1:0]  pwdata    = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;

  // parser copy kept by the bench
  logic [2:0]            ps_phase = PH_IDLE;
  logic [WORD_BITS-1:0]  ps_acc   = '0;
  logic                  ps_neg   = 1'b0;
  logic                  ps_saw   = 1'b0;
  logic                  ps_ovf   = 1'b0;
  logic [BASE_BITS-1:0]  ps_base  = '0;
  logic [INDEX_BITS-1:0] ps_pos   = '0;
  logic [BASE_BITS-1:0]  ps_radix = '0;

  num_t pending_nums [$];
  int   mismatches   = 0;
  int   items_fed    = 0;
  int   quiet_cycles = 0;
  int   rx_hold      = 0;
  bit   rx_calm      = 1'b0;
  bit   tx_calm      = 1'b0;

  string_to_unsigned_parser u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch          (in_ch),
    .in_first       (in_first),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_end_index  (out_end_index),
    .out_any_digits (out_any_digits),
    .out_overflow   (out_overflow),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short pauses, now and then a long one
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic int digit_val(input logic [CHAR_BITS-1:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LC_A && c <= CH_LC_Z) return int'(c - CH_LC_A) + 10;
    if (c >= CH_UC_A && c <= CH_UC_Z) return int'(c - CH_UC_A) + 10;
    return 255;
  endfunction

  function automatic logic is_blank(input logic [CHAR_BITS-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // build the result beat and go quiet until the next string start
  function automatic num_t close_number();
    num_t r;
    if (ps_ovf) r.value = '1;
    else if (ps_neg) r.value = -ps_acc;
    else r.value = ps_acc;
    r.end_index  = ps_saw ? ps_pos : '0;
    r.any_digits = ps_saw;
    r.overflow   = ps_ovf;
    ps_phase = PH_DONE;
    return r;
  endfunction

  // accumulate one digit; return 1 when the character ends the number
  function automatic logic take_digit(input logic [CHAR_BITS-1:0] c, output num_t r);
    int              d;
    longint unsigned top;
    longint unsigned lim;
    if (ps_base == BASE_AUTO) ps_base = BASE_DEC;
    d = digit_val(c);
    if (d >= ps_base) begin
      r = close_number();
      return 1'b1;
    end
    top = 64'hFFFF_FFFF / ps_base;
    lim = 64'hFFFF_FFFF % ps_base;
    if (ps_ovf || ps_acc > top || (ps_acc == top && d > lim)) begin
      ps_ovf = 1'b1;
    end else begin
      ps_acc = ps_acc * ps_base + d;
    end
    ps_saw = 1'b1;
    return 1'b0;
  endfunction

  function automatic logic start_number(input logic [CHAR_BITS-1:0] c, output num_t r);
    if ((ps_base == BASE_AUTO || ps_base == BASE_HEX) && c == CH_0) begin
      ps_phase = PH_ZERO;
      return 1'b0;
    end
    if (ps_base == BASE_AUTO) ps_base = BASE_DEC;
    ps_phase = PH_DIGITS;
    return take_digit(c, r);
  endfunction

  // advance the parser copy by one character; 1 means a result was built
  function automatic logic parse_char(input logic [CHAR_BITS-1:0] c, input logic f,
                                      output num_t r);
    logic done;
    num_t scratch;
    done = 1'b0;
    if (f) begin
      ps_phase = PH_LEAD;
      ps_acc   = '0;
      ps_neg   = 1'b0;
      ps_saw   = 1'b0;
      ps_ovf   = 1'b0;
      ps_base  = ps_radix;
      ps_pos   = '0;
    end else if (ps_phase == PH_IDLE || ps_phase == PH_DONE) begin
      return 1'b0;
    end
    case (ps_phase)
      PH_LEAD: begin
        if (is_blank(c)) begin
        end else if (c == CH_MINUS) begin
          ps_neg   = 1'b1;
          ps_phase = PH_SIGNED;
        end else if (c == CH_PLUS) begin
          ps_phase = PH_SIGNED;
        end else begin
          done = start_number(c, r);
        end
      end
      PH_SIGNED: begin
        done = start_number(c, r);
      end
      PH_ZERO: begin
        if (c == CH_LC_X || c == CH_UC_X) begin
          ps_base  = BASE_HEX;
          ps_phase = PH_DIGITS;
        end else begin
          if (ps_base == BASE_AUTO) ps_base = BASE_OCT;
          ps_phase = PH_DIGITS;
          void'(take_digit(CH_0, scratch));
          done = take_digit(c, r);
        end
      end
      default: begin
        done = take_digit(c, r);
      end
    endcase
    if (!done && ps_pos != '1) ps_pos++;
    return done;
  endfunction

  // drive one character beat, wait for it to be taken, then predict
  task automatic send_beat(input logic [CHAR_BITS-1:0] c, input logic f,
                           input logic typed, input num_t fixed);
    int   gap;
    num_t got;
    gap = (!tx_calm && $urandom_range(0, 3) == 0) ? pause_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch    <= c;
    in_first <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (f || (ps_phase != PH_IDLE && ps_phase != PH_DONE)) items_fed++;
    if (parse_char(c, f, got) && !typed) pending_nums.push_back(got);
    if (typed) pending_nums.push_back(fixed);
  endtask

  // hold input, drain results, let the pipeline empty
  task automatic settle_parser();
    in_valid <= 1'b0;
    while (pending_nums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radix(input logic [BASE_BITS-1:0] r);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RADIX_ADDR;
    pwdata  <= DATA_BITS'(r);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    ps_radix = r;
  endtask

  // blanks, sign, prefix and digits that fit the base, then mostly a terminator
  task automatic send_number_string();
    logic                 lead;
    logic [CHAR_BITS-1:0] c;
    int                   eff;
    int                   lim;
    int                   n;
    int                   i;
    int                   d;
    int                   pick;
    lead = 1'b1;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    for (i = 0; i < n; i++) begin
      c = ($urandom_range(0, 5) == 0) ? CH_SPACE : CHAR_BITS'($urandom_range(CH_TAB, CH_CR));
      send_beat(c, lead, 1'b0, NO_NUM);
      lead = 1'b0;
    end
    pick = $urandom_range(0, 3);
    if (pick < 2) begin
      send_beat((pick == 0) ? CH_MINUS : CH_PLUS, lead, 1'b0, NO_NUM);
      lead = 1'b0;
    end
    eff = ps_radix;
    if (ps_radix == BASE_AUTO || ps_radix == BASE_HEX) begin
      pick = $urandom_range(0, 3);
      if (pick < 2) begin
        send_beat(CH_0, lead, 1'b0, NO_NUM);
        lead = 1'b0;
        if (pick == 0) begin
          send_beat($urandom_range(0, 1) ? CH_LC_X : CH_UC_X, 1'b0, 1'b0, NO_NUM);
          eff = BASE_HEX;
        end else begin
          eff = (ps_radix == BASE_AUTO) ? BASE_OCT : BASE_HEX;
        end
      end else begin
        eff = (ps_radix == BASE_AUTO) ? BASE_DEC : BASE_HEX;
      end
    end
    lim = (eff > 36) ? 36 : eff;
    pick = $urandom_range(0, 7);
    n = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    for (i = 0; i < n; i++) begin
      d = $urandom_range(0, lim - 1);
      if (d < 10) c = CH_0 + CHAR_BITS'(d);
      else c = ($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + CHAR_BITS'(d - 10);
      send_beat(c, lead, 1'b0, NO_NUM);
      lead = 1'b0;
    end
    // end the number, or leave it open for the next string start
    if ($urandom_range(0, 9) != 0) begin
      if ($urandom_range(0, 7) == 0) begin
        c = 8'h00;
      end else begin
        do c = CHAR_BITS'($urandom_range(0, 255)); while (digit_val(c) < eff);
      end
      send_beat(c, lead, 1'b0, NO_NUM);
    end
    // trailing characters, which the parser ignores once the number has ended
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_beat(CHAR_BITS'($urandom_range(0, 255)), 1'b0,
                                              1'b0, NO_NUM);
    end
  endtask

  // loose characters, with string starts sprinkled in
  task automatic send_noise();
    logic [CHAR_BITS-1:0] c;
    int                   i;
    int                   n;
    n = $urandom_range(1, 8);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: c = CH_PLUS;
        1: c = CH_MINUS;
        2: c = CH_0;
        3: c = CH_LC_X;
        4: c = CH_SPACE;
        default: c = CHAR_BITS'($urandom_range(0, 255));
      endcase
      send_beat(c, $urandom_range(0, 3) == 0, 1'b0, NO_NUM);
    end
  endtask

  // result side: random stall runs, with calm stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 499) == 0) rx_calm = ~rx_calm;
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!rx_calm && $urandom_range(0, 3) == 0) rx_hold = pause_len();
    end
  end

  // compare each result beat with the oldest pending number
  always @(posedge clk) begin
    num_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_nums.size() == 0) begin
        $error("unexpected result beat: value %h end_index %0d", out_value, out_end_index);
        mismatches++;
      end else begin
        want = pending_nums.pop_front();
        if (out_value !== want.value) begin
          $error("value: expected %h, got %h", want.value, out_value);
          mismatches++;
        end
        if (out_end_index !== want.end_index) begin
          $error("end_index: expected %0d, got %0d", want.end_index, out_end_index);
          mismatches++;
        end
        if (out_any_digits !== want.any_digits) begin
          $error("any_digits: expected %b, got %b", want.any_digits, out_any_digits);
          mismatches++;
        end
        if (out_overflow !== want.overflow) begin
          $error("overflow: expected %b, got %b", want.overflow, out_overflow);
          mismatches++;
        end
      end
    end
  end

  // watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int k;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, radix left at its reset value until a row sets it
    for (k = 0; k < N_DIRECTED; k++) begin
      if (DIRECTED[k].set_radix) begin
        settle_parser();
        write_radix(DIRECTED[k].radix);
      end
      send_beat(DIRECTED[k].ch, DIRECTED[k].first, DIRECTED[k].typed, DIRECTED[k].res);
    end

    // random strings in phases, each under its own radix
    while (items_fed < RANDOM_ITEMS) begin
      settle_parser();
      case ($urandom_range(0, 9))
        0: write_radix(BASE_AUTO);
        1: write_radix(6'd36);
        2: write_radix(6'd1);
        3: write_radix('1);
        4: write_radix(BASE_HEX);
        5: write_radix(BASE_OCT);
        6: write_radix(BASE_DEC);
        7: write_radix(6'd2);
        default: write_radix(BASE_BITS'($urandom_range(0, 63)));
      endcase
      repeat ($urandom_range(10, 30)) begin
        if ($urandom_range(0, 15) == 0) tx_calm = ~tx_calm;
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_number_string();
      end
    end

    settle_parser();
    if (mismatches == 0 && pending_nums.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
